FILE: hdl/rfs_pkg.sv
package rfs_pkg;

   // Action codes carried in each request
   localparam logic ACTION_PAIR = 1'b0;
   localparam logic ACTION_DC   = 1'b1;

   // Q15 arithmetic constants
   localparam int HALVE_MUL  = 16383;
   localparam int ROUND_BIAS = 16384;
   localparam int Q15_SHIFT  = 15;

   typedef logic signed [15:0] q15_type;

   typedef struct packed {
      logic    action;
      q15_type left_re;
      q15_type left_im;
      q15_type right_re;
      q15_type right_im;
      q15_type twiddle_re;
      q15_type twiddle_im;
      logic    last_pair;
   } req_payload_type;

   typedef struct packed {
      q15_type out_left_re;
      q15_type out_left_im;
      q15_type out_right_re;
      q15_type out_right_im;
      logic    end_of_frame;
   } rsp_payload_type;

endpackage

FILE: hdl/rfs_req_if.sv
interface rfs_req_if;
   logic                     valid;
   logic                     ready;
   rfs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

FILE: hdl/rfs_rsp_if.sv
interface rfs_rsp_if;
   logic                     valid;
   logic                     ready;
   rfs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

FILE: hdl/real_fft_split_q15_top.sv
// Channel   | Role            | Payload
// ----------+-----------------+-------------------------------------------------
// req_bus   | sink, requests  | action, bin k / bin N-k samples, twiddle, last
// rsp_bus   | source, results | bin k and bin N-k results, end_of_frame
//
// One transaction per clock sustained while rsp_bus is ready; an accepted request
// passes the input register, then the result register, where it turns valid.
// The four twiddle products sit in one combinational pass between the two.
// reset (synchronous, active high) clears both valid flags only.
// A stalled result holds in the result register while the input register
// still takes one more transaction; req_bus.ready drops only when both are full.
module real_fft_split_q15_top (
   input  logic      clock,
   input  logic      reset,
   rfs_req_if.sink   req_bus,
   rfs_rsp_if.source rsp_bus
);

   // Round-to-nearest halving of a Q15 sample: (x*16383 + 16384) >> 15
   function automatic rfs_pkg::q15_type halve_q15(input rfs_pkg::q15_type x);
      logic signed [31:0] acc;
      acc = 32'(x) * 32'(rfs_pkg::HALVE_MUL) + 32'(rfs_pkg::ROUND_BIAS);
      return acc[30:rfs_pkg::Q15_SHIFT];
   endfunction

   logic                     in_valid_ff, in_valid_in;
   rfs_pkg::req_payload_type in_data_ff;
   logic                     out_valid_ff, out_valid_in;
   rfs_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic                     out_take;
   logic                     in_take;

   // Handshake: the result register frees up when empty or being drained
   assign out_take       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !in_valid_ff || out_take;
   assign in_take        = req_bus.valid && req_bus.ready;
   assign in_valid_in    = in_take || (in_valid_ff && !out_take);
   assign out_valid_in   = out_take ? in_valid_ff : out_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_take) begin
         in_data_ff <= req_bus.payload;
      end
   end

   // Butterfly datapath
   rfs_pkg::q15_type   lr, li, rr, ri;
   logic signed [16:0] s_re, s_im, diff_re, diff_im, dc_sum, dc_diff;
   rfs_pkg::q15_type   d_re, d_im;
   logic signed [31:0] m_rr, m_ii, m_ri, m_ir;
   logic signed [32:0] acc_re, acc_im;
   logic signed [17:0] p_re, p_im;
   logic signed [18:0] sum_lre, sum_lim, sum_rre, sum_rim;

   always_comb begin
      lr = halve_q15(in_data_ff.left_re);
      li = halve_q15(in_data_ff.left_im);
      rr = halve_q15(in_data_ff.right_re);
      ri = halve_q15(in_data_ff.right_im);

      s_re    = 17'(lr) + 17'(rr);
      s_im    = 17'(li) - 17'(ri);
      diff_re = 17'(lr) - 17'(rr);
      diff_im = 17'(li) + 17'(ri);
      d_re    = diff_re[15:0];
      d_im    = diff_im[15:0];

      // Twiddle rotation of the difference term
      m_rr = 32'(d_re) * 32'(in_data_ff.twiddle_re);
      m_ii = 32'(d_im) * 32'(in_data_ff.twiddle_im);
      m_ri = 32'(d_re) * 32'(in_data_ff.twiddle_im);
      m_ir = 32'(d_im) * 32'(in_data_ff.twiddle_re);
      acc_re = 33'(m_rr) - 33'(m_ii) + 33'(rfs_pkg::ROUND_BIAS);
      acc_im = 33'(m_ri) + 33'(m_ir) + 33'(rfs_pkg::ROUND_BIAS);
      p_re   = acc_re[32:rfs_pkg::Q15_SHIFT];
      p_im   = acc_im[32:rfs_pkg::Q15_SHIFT];

      sum_lre = 19'(s_re) + 19'(p_re);
      sum_lim = 19'(s_im) + 19'(p_im);
      sum_rre = 19'(s_re) - 19'(p_re);
      sum_rim = 19'(p_im) - 19'(s_im);

      // DC / Nyquist terms
      dc_sum  = 17'(lr) + 17'(li);
      dc_diff = 17'(lr) - 17'(li);

      out_data_in.end_of_frame = in_data_ff.last_pair;
      if (in_data_ff.action == rfs_pkg::ACTION_DC) begin
         out_data_in.out_left_re  = dc_sum[15:0];
         out_data_in.out_left_im  = '0;
         out_data_in.out_right_re = dc_diff[15:0];
         out_data_in.out_right_im = '0;
      end else begin
         // floor halving, then keep the low 16 bits
         out_data_in.out_left_re  = sum_lre[16:1];
         out_data_in.out_left_im  = sum_lim[16:1];
         out_data_in.out_right_re = sum_rre[16:1];
         out_data_in.out_right_im = sum_rim[16:1];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_take && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_data_ff;

endmodule

FILE: hdl/rfs_checker.sv
module rfs_checker (
   input logic       clock,
   input logic       reset,
   rfs_req_if.sink   req_bus,
   rfs_rsp_if.source rsp_bus
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

   // A pending result is not withdrawn
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid)
      else $error("result valid dropped while stalled");

   // With no result pending the block always takes a request
   a_ready_when_empty: assert property (@(posedge clock)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("request stalled with empty result register");

   // A DC transaction with a free output passes the input and result registers and
   // shows up with zero imaginary parts and its end marker copied
   a_dc_result: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.payload.action == rfs_pkg::ACTION_DC)
      ##1 rsp_bus.ready
      |=> rsp_bus.valid && rsp_bus.payload.out_left_im == '0
          && rsp_bus.payload.out_right_im == '0
          && rsp_bus.payload.end_of_frame == $past(req_bus.payload.last_pair, 2))
      else $error("DC result malformed");

endmodule

bind real_fft_split_q15_top rfs_checker u_rfs_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

FILE: tb/sv/tb_real_fft_split_q15_top.sv
`timescale 1ns / 1ps

module tb_real_fft_split_q15_top;

   // Directed row: stimulus plus an optional hand-computed answer
   typedef struct {
      rfs_pkg::req_payload_type stim;
      bit                       fixed;
      rfs_pkg::rsp_payload_type answer;
   } table_row_type;

   typedef struct {
      bit                       fixed;
      rfs_pkg::rsp_payload_type answer;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   rfs_req_if req_bus ();
   rfs_rsp_if rsp_bus ();

   real_fft_split_q15_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   table_row_type            directed_rows[$];
   answer_type               table_answers[$];
   rfs_pkg::rsp_payload_type pending_bins[$];
   int                       mismatch_count   = 0;
   int                       send_idle_pct    = 0;
   int                       rsp_stall_pct    = 0;
   bit                       hold_off_request = 1'b0;

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Q15 halving: (x*16383 + 16384) >> 15, floor
   function automatic longint halve_q15(rfs_pkg::q15_type x);
      return (longint'(x) * rfs_pkg::HALVE_MUL + rfs_pkg::ROUND_BIAS) >>> rfs_pkg::Q15_SHIFT;
   endfunction

   // Expected result of one split butterfly transaction
   function automatic rfs_pkg::rsp_payload_type split_butterfly(
         rfs_pkg::req_payload_type r);
      longint                   lr, li, rr, ri, twr, twi;
      longint                   s_re, s_im, d_re, d_im, p_re, p_im;
      rfs_pkg::rsp_payload_type res;
      lr = halve_q15(r.left_re);
      li = halve_q15(r.left_im);
      res.end_of_frame = r.last_pair;
      if (r.action == rfs_pkg::ACTION_DC) begin
         res.out_left_re  = rfs_pkg::q15_type'(lr + li);
         res.out_left_im  = '0;
         res.out_right_re = rfs_pkg::q15_type'(lr - li);
         res.out_right_im = '0;
         return res;
      end
      rr   = halve_q15(r.right_re);
      ri   = halve_q15(r.right_im);
      twr  = longint'(r.twiddle_re);
      twi  = longint'(r.twiddle_im);
      s_re = lr + rr;
      s_im = li - ri;
      d_re = longint'(rfs_pkg::q15_type'(lr - rr));
      d_im = longint'(rfs_pkg::q15_type'(li + ri));
      // twiddle rotation of the difference term, rounded
      p_re = (d_re * twr - d_im * twi + rfs_pkg::ROUND_BIAS) >>> rfs_pkg::Q15_SHIFT;
      p_im = (d_re * twi + d_im * twr + rfs_pkg::ROUND_BIAS) >>> rfs_pkg::Q15_SHIFT;
      res.out_left_re  = rfs_pkg::q15_type'((s_re + p_re) >>> 1);
      res.out_left_im  = rfs_pkg::q15_type'((s_im + p_im) >>> 1);
      res.out_right_re = rfs_pkg::q15_type'((s_re - p_re) >>> 1);
      res.out_right_im = rfs_pkg::q15_type'((p_im - s_im) >>> 1);
      return res;
   endfunction

   // Sample value biased toward the extremes and small magnitudes
   function automatic rfs_pkg::q15_type random_q15();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return rfs_pkg::q15_type'(int'($urandom_range(16)) - 8);
         default: return rfs_pkg::q15_type'($urandom);
      endcase
   endfunction

   function automatic rfs_pkg::req_payload_type random_item();
      rfs_pkg::req_payload_type r;
      r.action     = ($urandom_range(3) == 0) ? rfs_pkg::ACTION_DC : rfs_pkg::ACTION_PAIR;
      r.left_re    = random_q15();
      r.left_im    = random_q15();
      r.right_re   = random_q15();
      r.right_im   = random_q15();
      r.twiddle_re = random_q15();
      r.twiddle_im = random_q15();
      r.last_pair  = ($urandom_range(7) == 0);
      // midpoint bin: mirror sample equals the bin k sample
      if ($urandom_range(15) == 0) begin
         r.right_re = r.left_re;
         r.right_im = r.left_im;
      end
      return r;
   endfunction

   task automatic add_row(input logic act, input int lre, input int lim, input int rre,
                          input int rim, input int twr, input int twi, input logic last,
                          input bit fixed = 1'b0, input int a_lre = 0, input int a_rre = 0);
      table_row_type row;
      row.stim.action      = act;
      row.stim.left_re     = rfs_pkg::q15_type'(lre);
      row.stim.left_im     = rfs_pkg::q15_type'(lim);
      row.stim.right_re    = rfs_pkg::q15_type'(rre);
      row.stim.right_im    = rfs_pkg::q15_type'(rim);
      row.stim.twiddle_re  = rfs_pkg::q15_type'(twr);
      row.stim.twiddle_im  = rfs_pkg::q15_type'(twi);
      row.stim.last_pair   = last;
      row.fixed            = fixed;
      row.answer.out_left_re  = rfs_pkg::q15_type'(a_lre);
      row.answer.out_left_im  = '0;
      row.answer.out_right_re = rfs_pkg::q15_type'(a_rre);
      row.answer.out_right_im = '0;
      row.answer.end_of_frame = last;
      directed_rows.push_back(row);
   endtask

   // Offer one transaction, with random idle cycles ahead of it
   task automatic send_item(input rfs_pkg::req_payload_type p, input bit fixed = 1'b0,
                            input rfs_pkg::rsp_payload_type answer = '0);
      answer_type a;
      a.fixed  = fixed;
      a.answer = answer;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      table_answers.push_back(a);
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Sender pauses until every expected result is back; an accepted transaction
   // still waiting for its result keeps its entry in pending_bins
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_bins.size() != 0 || table_answers.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_item(random_item());
      drain();
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
         mismatch_count++;
      end
   endtask

   // Result receiver: random stalls, or a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (64) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Transaction monitor: predict on acceptance, check on delivery
   always @(posedge clock) begin
      answer_type               a;
      rfs_pkg::rsp_payload_type want;
      rfs_pkg::rsp_payload_type got;
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            a = table_answers.pop_front();
            pending_bins.push_back(a.fixed ? a.answer : split_butterfly(req_bus.payload));
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = rsp_bus.payload;
            if (pending_bins.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $realtime, got);
               mismatch_count++;
            end else begin
               want = pending_bins.pop_front();
               compare_field("out_left_re", want.out_left_re, got.out_left_re);
               compare_field("out_left_im", want.out_left_im, got.out_left_im);
               compare_field("out_right_re", want.out_right_re, got.out_right_re);
               compare_field("out_right_im", want.out_right_im, got.out_right_im);
               compare_field("end_of_frame", 16'(want.end_of_frame), 16'(got.end_of_frame));
            end
         end
      end
   end

   // Main sequence
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;

      // DC items: sum and difference of the halved bin k sample
      add_row(rfs_pkg::ACTION_DC, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0);
      add_row(rfs_pkg::ACTION_DC, 32767, 32767, 0, 0, 0, 0, 1'b0, 1'b1, 32766, 0);
      add_row(rfs_pkg::ACTION_DC, -32768, -32768, 0, 0, 0, 0, 1'b0, 1'b1, -32766, 0);
      add_row(rfs_pkg::ACTION_DC, 32767, -32768, 1234, -99, 500, 7, 1'b1, 1'b1, 0, 32766);
      add_row(rfs_pkg::ACTION_DC, -32768, 32767, 32767, 32767, 32767, 32767, 1'b0, 1'b1,
              0, -32766);
      add_row(rfs_pkg::ACTION_DC, 1, -1, -32768, -32768, -32768, -32768, 1'b1);
      // pair butterflies
      add_row(rfs_pkg::ACTION_PAIR, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0);
      add_row(rfs_pkg::ACTION_PAIR, 32767, 0, 0, 0, 0, 0, 1'b0, 1'b1, 8191, 8191);
      add_row(rfs_pkg::ACTION_PAIR, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, 32767, 32767, -32768, -32768, -32768, -32768, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, -32768, -32768, 32767, 32767, 32767, -32768, 1'b1);
      add_row(rfs_pkg::ACTION_PAIR, 32767, -32768, -32768, 32767, -32768, 32767, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, 1, -1, -1, 1, 32767, 0, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, 12000, -7000, 3000, 25000, 32767, 0, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, -4321, 8765, 1111, -2222, 0, 32767, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, 20000, 20000, -20000, 20000, 23170, -23170, 1'b0);
      // midpoint bin: both samples are the same bin
      add_row(rfs_pkg::ACTION_PAIR, 12000, -7000, 12000, -7000, 0, -32768, 1'b0);
      add_row(rfs_pkg::ACTION_PAIR, -32768, 32767, -32768, 32767, 0, -32767, 1'b1);
      add_row(rfs_pkg::ACTION_PAIR, 32767, 32767, 32767, 32767, 0, 32767, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].answer);
      drain();

      run_phase(0, 0, 400);
      run_phase(66, 0, 400);
      run_phase(0, 66, 400);
      run_phase(18, 18, 400);

      // long receiver hold-off while the sender keeps offering
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_off_request = 1'b1;
      repeat (40) send_item(random_item());
      drain();

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/rfs_pkg.sv
hdl/rfs_req_if.sv
hdl/rfs_rsp_if.sv
hdl/real_fft_split_q15_top.sv
hdl/rfs_checker.sv
tb/sv/tb_real_fft_split_q15_top.sv
